### rtl/core/wave_grid_fdtd_step_top_defines.svh
// Assertion macros shared by the RTL of the wave grid block.
`ifndef WAVE_GRID_FDTD_STEP_TOP_DEFINES_SVH
`define WAVE_GRID_FDTD_STEP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define WGFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wgfd: same-cycle check failed");
`define WGFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wgfd: next-cycle check failed");
`else
`define WGFD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WGFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/wgfd_pkg.sv
package wgfd_pkg;

    localparam int GRID_X        = 128;
    localparam int GRID_Y        = 128;
    localparam int WALL_COLUMN   = 15;
    localparam int SOURCE_MARGIN = 5;
    localparam int FIELD_BITS    = 24;

    localparam int CELLS     = GRID_X * GRID_Y;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int X_W       = $clog2(GRID_X);
    localparam int YC_W      = $clog2(GRID_Y + 1);
    localparam int P_W       = $clog2(CELLS + GRID_X);
    localparam int ACT_W     = 2;
    localparam int CELL_W    = 7;
    localparam int COEF_W    = 31;
    localparam int REG_W     = 7;
    localparam int CFG_IDX_W = 3;

    // Lens test widths: signed offsets, their squares and the weighted terms.
    localparam int XY_MAX = (X_W > YC_W) ? X_W : YC_W;
    localparam int D_W    = ((XY_MAX > REG_W) ? XY_MAX : REG_W) + 1;
    localparam int SQ_W   = 2 * D_W;
    localparam int R2_W   = 2 * REG_W;
    localparam int TERM_W = SQ_W + R2_W;
    localparam int LSUM_W = TERM_W + 1;

    // Update datapath widths.
    localparam int LAP_W  = FIELD_BITS + 3;
    localparam int PROD_W = LAP_W + COEF_W + 1;
    localparam int NV_W   = LAP_W + 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_STEP  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_OUTSIDE = 3'd0,
        REG_COEF_INSIDE  = 3'd1,
        REG_LENS_CX      = 3'd2,
        REG_LENS_CY      = 3'd3,
        REG_LENS_RX      = 3'd4,
        REG_LENS_RY      = 3'd5,
        REG_HOLE_LOW     = 3'd6,
        REG_HOLE_HIGH    = 3'd7
    } t_cfg_index;

endpackage

### rtl/core/wgfd_ram.sv
module wgfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

### rtl/core/wave_grid_fdtd_step_top.sv
// Two-level 2D scalar wave grid with a lens region and an apertured wall.
// Input channel (i_in_valid / o_in_stall) takes one transaction per action:
// step, read one cell, clear, or no-op (ACT_NONE). Every action returns exactly one result
// transaction on the output channel (o_out_valid / i_out_stall).
// Configuration registers are written through i_cfg_wr_en / i_cfg_index /
// i_cfg_wdata, by the user only while no transaction is in flight; the block does not enforce this.
// One item is worked on at a time; o_in_stall is high until its result has
// been placed in the output register.
// Step: the grid is swept once in raster order through a single read port of
// each level memory; the five-point stencil comes from a two-row shift line,
// and the new level is read, updated and written back through the other
// memory's ports. A clear writes one cell of each memory per cycle.
// After reset the block runs a clearing pass over all CELLS cells with
// o_in_stall high; configuration writes are taken during that pass.
// A stalled output keeps its result; the block waits with the next
// result until the output register has been taken.
`include "wave_grid_fdtd_step_top_defines.svh"

module wave_grid_fdtd_step_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [wgfd_pkg::ACT_W-1:0]        i_action,
    input  logic signed [wgfd_pkg::FIELD_BITS-1:0] i_source_now,
    input  logic [wgfd_pkg::CELL_W-1:0]       i_cell_x,
    input  logic [wgfd_pkg::CELL_W-1:0]       i_cell_y,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [wgfd_pkg::FIELD_BITS-1:0] o_cell_value,
    output logic                              o_saturated,
    input  logic                              i_cfg_wr_en,
    input  logic [wgfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wgfd_pkg::COEF_W-1:0]       i_cfg_wdata
);
    import wgfd_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_STEP,
        S_FINISH
    } t_state;

    localparam logic signed [NV_W-1:0] F_MAX = NV_W'((64'sd1 <<< (FIELD_BITS - 1)) - 64'sd1);
    localparam logic signed [NV_W-1:0] F_MIN = -F_MAX - NV_W'(1);
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sh8000_0000);

    t_state r_state;
    logic   r_bank;
    logic [P_W-1:0]  r_cnt;
    logic [X_W-1:0]  r_px;
    logic [YC_W-1:0] r_py;
    logic   r_issue;
    logic   r_sat;
    logic   r_clear_reply;
    logic   r_rd_ok;
    logic   r_v1;
    logic   r_pv1;
    logic [4:0] r_cv;
    logic   r_out_valid;
    logic signed [FIELD_BITS-1:0] r_out_value;
    logic   r_out_sat;
    logic signed [FIELD_BITS-1:0] r_res_value;
    logic   r_res_sat;

    logic [COEF_W-1:0] r_coef_out, r_coef_in;
    logic [REG_W-1:0]  r_lcx, r_lcy, r_lrx, r_lry, r_hole_lo, r_hole_hi;
    logic [R2_W-1:0]   r_rx2, r_ry2;
    logic [2*R2_W-1:0] r_rxry2;

    logic signed [FIELD_BITS-1:0] r_src;

    // Stage registers of the sweep pipeline.
    logic [ADDR_W-1:0] r_p1;
    logic [X_W-1:0]    r_px1;
    logic [YC_W-1:0]   r_py1;
    logic [ADDR_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5;
    logic r_edge1, r_edge2, r_edge3, r_edge4, r_edge5;
    logic signed [FIELD_BITS-1:0] r_line [2*GRID_X+1];
    logic signed [FIELD_BITS-1:0] r_prev2, r_prev3, r_prev4, r_prev5;
    logic signed [FIELD_BITS-1:0] r_cen3, r_cen4, r_cen5;
    logic signed [LAP_W-1:0] r_lap3, r_lap4;
    logic [COEF_W-1:0] r_coef4;
    logic signed [PROD_W-1:0] r_prod5;
    logic signed [D_W-1:0] r_ox1, r_oy1;
    logic [SQ_W-1:0] r_sqx2, r_sqy2;
    logic [TERM_W-1:0] r_tx3, r_ty3;

    logic signed [D_W-1:0] n_ox, n_oy;
    logic n_edge;
    logic [P_W-1:0] n_c;
    logic signed [SQ_W-1:0] sqx, sqy;
    logic [TERM_W-1:0] tx, ty;
    logic [LSUM_W-1:0] lsum;
    logic in_lens;
    logic signed [LAP_W-1:0] lap;
    logic signed [PROD_W-1:0] prod, prod_rnd;
    logic signed [LAP_W-1:0] scaled;
    logic signed [NV_W-1:0] nv;
    logic signed [FIELD_BITS-1:0] nv_clamped;
    logic nv_sat;
    logic signed [FIELD_BITS-1:0] ov;
    logic [ADDR_W-1:0] rd_cell_addr;
    logic rd_cell_ok;
    logic in_accept, out_take, issue_last, drained, res_load;

    logic [ADDR_W-1:0] cur_rd_addr, nxt_rd_addr;
    logic [ADDR_W-1:0] cur_wr_addr, nxt_wr_addr;
    logic cur_wr_en, nxt_wr_en;
    logic [FIELD_BITS-1:0] cur_wr_data, nxt_wr_data;
    logic [FIELD_BITS-1:0] cur_rd_data, nxt_rd_data;
    logic [ADDR_W-1:0] a_rd_addr, b_rd_addr, a_wr_addr, b_wr_addr;
    logic a_wr_en, b_wr_en;
    logic [FIELD_BITS-1:0] a_wr_data, b_wr_data, a_rd_data, b_rd_data;

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_take   = r_out_valid && !i_out_stall;
    assign issue_last = (r_cnt == P_W'(CELLS + GRID_X - 1));
    assign drained    = !r_issue && !r_v1 && (r_cv == '0);
    assign res_load   = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    // Center of the stencil trails the cell being fetched by one row.
    assign n_c    = r_cnt - P_W'(GRID_X);
    assign n_edge = (r_px == '0) || (r_px == X_W'(GRID_X - 1)) ||
                    (r_py == YC_W'(1)) || (r_py == YC_W'(GRID_Y));
    assign n_ox   = D_W'(int'(r_px) - int'(r_lcx));
    assign n_oy   = D_W'(int'(r_py) - 1 - int'(r_lcy));

    assign rd_cell_addr = ADDR_W'(int'(i_cell_y) * GRID_X + int'(i_cell_x));
    assign rd_cell_ok   = (int'(i_cell_x) < GRID_X) && (int'(i_cell_y) < GRID_Y);

    // Source column and wall column are applied to the current level as it
    // streams past, and written back so that the next step sees them.
    always_comb begin
        ov = signed'(cur_rd_data);
        if ((r_px1 == '0) && (int'(r_py1) > SOURCE_MARGIN) &&
            (int'(r_py1) < GRID_Y - SOURCE_MARGIN)) begin
            ov = r_src;
        end
        if ((WALL_COLUMN < GRID_X) && (int'(r_px1) == WALL_COLUMN) &&
            ((int'(r_py1) < int'(r_hole_lo)) || (int'(r_py1) > int'(r_hole_hi)))) begin
            ov = '0;
        end
    end

    assign lap = LAP_W'(r_line[0]) + LAP_W'(r_line[GRID_X-1]) + LAP_W'(r_line[GRID_X+1])
               + LAP_W'(r_line[2*GRID_X]) - (LAP_W'(r_line[GRID_X]) <<< 2);

    assign sqx  = r_ox1 * r_ox1;
    assign sqy  = r_oy1 * r_oy1;
    assign tx   = r_sqx2 * r_ry2;
    assign ty   = r_sqy2 * r_rx2;
    assign lsum = {1'b0, r_tx3} + {1'b0, r_ty3};
    assign in_lens = lsum < LSUM_W'(r_rxry2);

    assign prod     = r_lap4 * $signed({1'b0, r_coef4});
    assign prod_rnd = r_prod5 + RND_HALF;
    assign scaled   = LAP_W'(prod_rnd >>> 32);
    assign nv = (NV_W'(r_cen5) <<< 1) - NV_W'(r_prev5) + NV_W'(scaled);

    always_comb begin
        nv_sat = 1'b0;
        nv_clamped = FIELD_BITS'(nv);
        if (nv > F_MAX) begin
            nv_sat = 1'b1;
            nv_clamped = FIELD_BITS'(F_MAX);
        end else if (nv < F_MIN) begin
            nv_sat = 1'b1;
            nv_clamped = FIELD_BITS'(F_MIN);
        end
        if (r_edge5) begin
            nv_clamped = '0;
        end
    end

    // Port steering between the current and the next level.
    always_comb begin
        cur_rd_addr = (r_state == S_STEP) ? r_cnt[ADDR_W-1:0] : rd_cell_addr;
        nxt_rd_addr = n_c[ADDR_W-1:0];
        cur_wr_en   = (r_state == S_STEP) && r_v1 && r_pv1;
        cur_wr_addr = r_p1;
        cur_wr_data = ov;
        nxt_wr_en   = r_cv[4];
        nxt_wr_addr = r_c5;
        nxt_wr_data = nv_clamped;
        if (r_state == S_CLEAR) begin
            cur_wr_en   = 1'b1;
            cur_wr_addr = r_cnt[ADDR_W-1:0];
            cur_wr_data = '0;
            nxt_wr_en   = 1'b1;
            nxt_wr_addr = r_cnt[ADDR_W-1:0];
            nxt_wr_data = '0;
        end
        if (!r_bank) begin
            a_rd_addr = cur_rd_addr; a_wr_en = cur_wr_en;
            a_wr_addr = cur_wr_addr; a_wr_data = cur_wr_data;
            b_rd_addr = nxt_rd_addr; b_wr_en = nxt_wr_en;
            b_wr_addr = nxt_wr_addr; b_wr_data = nxt_wr_data;
            cur_rd_data = a_rd_data; nxt_rd_data = b_rd_data;
        end else begin
            b_rd_addr = cur_rd_addr; b_wr_en = cur_wr_en;
            b_wr_addr = cur_wr_addr; b_wr_data = cur_wr_data;
            a_rd_addr = nxt_rd_addr; a_wr_en = nxt_wr_en;
            a_wr_addr = nxt_wr_addr; a_wr_data = nxt_wr_data;
            cur_rd_data = b_rd_data; nxt_rd_data = a_rd_data;
        end
    end

    wgfd_ram #(.WIDTH(FIELD_BITS), .DEPTH(CELLS)) u_level_a (
        .i_clk     (i_clk),
        .i_wr_en   (a_wr_en),
        .i_wr_addr (a_wr_addr),
        .i_wr_data (a_wr_data),
        .i_rd_addr (a_rd_addr),
        .o_rd_data (a_rd_data)
    );

    wgfd_ram #(.WIDTH(FIELD_BITS), .DEPTH(CELLS)) u_level_b (
        .i_clk     (i_clk),
        .i_wr_en   (b_wr_en),
        .i_wr_addr (b_wr_addr),
        .i_wr_data (b_wr_data),
        .i_rd_addr (b_rd_addr),
        .o_rd_data (b_rd_data)
    );

    // Control, configuration and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_bank        <= 1'b0;
            r_cnt         <= '0;
            r_px          <= '0;
            r_py          <= '0;
            r_issue       <= 1'b0;
            r_sat         <= 1'b0;
            r_clear_reply <= 1'b0;
            r_rd_ok       <= 1'b0;
            r_v1          <= 1'b0;
            r_pv1         <= 1'b0;
            r_cv          <= '0;
            r_out_valid   <= 1'b0;
            r_out_sat     <= 1'b0;
            r_res_sat     <= 1'b0;
            r_coef_out    <= COEF_W'(298262);
            r_coef_in     <= COEF_W'(103204);
            r_lcx         <= REG_W'(50);
            r_lcy         <= REG_W'(50);
            r_lrx         <= REG_W'(10);
            r_lry         <= REG_W'(40);
            r_hole_lo     <= REG_W'(50);
            r_hole_hi     <= REG_W'(80);
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_index'(i_cfg_index))
                    REG_COEF_OUTSIDE: r_coef_out <= i_cfg_wdata;
                    REG_COEF_INSIDE:  r_coef_in  <= i_cfg_wdata;
                    REG_LENS_CX:      r_lcx      <= i_cfg_wdata[REG_W-1:0];
                    REG_LENS_CY:      r_lcy      <= i_cfg_wdata[REG_W-1:0];
                    REG_LENS_RX:      r_lrx      <= i_cfg_wdata[REG_W-1:0];
                    REG_LENS_RY:      r_lry      <= i_cfg_wdata[REG_W-1:0];
                    REG_HOLE_LOW:     r_hole_lo  <= i_cfg_wdata[REG_W-1:0];
                    REG_HOLE_HIGH:    r_hole_hi  <= i_cfg_wdata[REG_W-1:0];
                    default: ;
                endcase
            end

            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end

            r_v1 <= (r_state == S_STEP) && r_issue;
            r_cv <= {r_cv[3:0], (r_state == S_STEP) && r_issue && (r_py != '0)};
            if (r_cv[4] && nv_sat && !r_edge5) begin
                r_sat <= 1'b1;
            end

            case (r_state)
                S_CLEAR: begin
                    if (r_cnt == P_W'(CELLS - 1)) begin
                        r_cnt <= '0;
                        if (r_clear_reply) begin
                            r_res_value <= '0;
                            r_res_sat   <= 1'b0;
                            r_state     <= S_FINISH;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_cnt <= r_cnt + P_W'(1);
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_cnt   <= '0;
                        r_px    <= '0;
                        r_py    <= '0;
                        r_rd_ok <= rd_cell_ok;
                        case (t_action'(i_action))
                            ACT_STEP: begin
                                r_sat   <= 1'b0;
                                r_issue <= 1'b1;
                                r_state <= S_STEP;
                            end
                            ACT_READ: begin
                                r_state <= S_READ;
                            end
                            ACT_CLEAR: begin
                                r_clear_reply <= 1'b1;
                                r_state       <= S_CLEAR;
                            end
                            default: begin
                                r_res_value <= '0;
                                r_res_sat   <= 1'b0;
                                r_state     <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_res_value <= r_rd_ok ? signed'(cur_rd_data) : '0;
                    r_res_sat   <= 1'b0;
                    r_state     <= S_FINISH;
                end
                S_STEP: begin
                    if (r_issue) begin
                        r_pv1   <= (r_py < YC_W'(GRID_Y));
                        r_cnt   <= r_cnt + P_W'(1);
                        if (r_px == X_W'(GRID_X - 1)) begin
                            r_px <= '0;
                            r_py <= r_py + YC_W'(1);
                        end else begin
                            r_px <= r_px + X_W'(1);
                        end
                        if (issue_last) begin
                            r_issue <= 1'b0;
                        end
                    end else if (drained) begin
                        r_bank      <= ~r_bank;
                        r_res_value <= '0;
                        r_res_sat   <= r_sat;
                        r_state     <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (res_load) begin
                        r_out_value   <= r_res_value;
                        r_out_sat     <= r_res_sat;
                        r_clear_reply <= 1'b0;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Sweep datapath: fetch, stencil, coefficient select, multiply, update.
    always_ff @(posedge i_clk) begin
        r_rx2   <= r_lrx * r_lrx;
        r_ry2   <= r_lry * r_lry;
        r_rxry2 <= r_rx2 * r_ry2;

        if (in_accept) begin
            r_src <= i_source_now;
        end

        r_p1    <= r_cnt[ADDR_W-1:0];
        r_px1   <= r_px;
        r_py1   <= r_py;
        r_c1    <= n_c[ADDR_W-1:0];
        r_edge1 <= n_edge;
        r_ox1   <= n_ox;
        r_oy1   <= n_oy;

        if (r_v1) begin
            r_line[0] <= ov;
            for (int i = 1; i <= 2 * GRID_X; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
        r_prev2 <= signed'(nxt_rd_data);
        r_c2    <= r_c1;
        r_edge2 <= r_edge1;
        r_sqx2  <= unsigned'(sqx);
        r_sqy2  <= unsigned'(sqy);

        r_lap3  <= lap;
        r_cen3  <= r_line[GRID_X];
        r_prev3 <= r_prev2;
        r_c3    <= r_c2;
        r_edge3 <= r_edge2;
        r_tx3   <= tx;
        r_ty3   <= ty;

        r_lap4  <= r_lap3;
        r_coef4 <= in_lens ? r_coef_in : r_coef_out;
        r_cen4  <= r_cen3;
        r_prev4 <= r_prev3;
        r_c4    <= r_c3;
        r_edge4 <= r_edge3;

        r_prod5 <= prod;
        r_cen5  <= r_cen4;
        r_prev5 <= r_prev4;
        r_c5    <= r_c4;
        r_edge5 <= r_edge4;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cell_value = r_out_value;
    assign o_saturated  = r_out_sat;

    `WGFD_ASSERT_NEXT(a_read_goes_to_read, i_clk, i_rst_n, in_accept && (i_action == ACT_READ), r_state == S_READ)
    `WGFD_ASSERT_IMPL(a_write_behind_read, i_clk, i_rst_n, r_cv[4] && r_issue, n_c > P_W'(r_c5))
    `WGFD_ASSERT_IMPL(a_finish_drained, i_clk, i_rst_n, r_state == S_FINISH, (r_cv == '0) && !r_v1)
    `WGFD_ASSERT_NEXT(a_result_waits, i_clk, i_rst_n, (r_state == S_FINISH) && r_out_valid && i_out_stall, r_state == S_FINISH)
endmodule

### tb/wave_grid_fdtd_step_top_test.sv
module wave_grid_fdtd_step_top_test;
    import wgfd_pkg::*;

    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct {
        logic signed [FIELD_BITS-1:0] value;
        bit                           sat;
    } cell_result_t;

    // Tracks both time levels of the grid and the expected result of every
    // accepted transaction.
    class field_scoreboard;
        int           level[2][CELLS];
        bit           bank;
        longint       coef_out;
        longint       coef_in;
        longint       cx, cy, rx, ry, hlo, hhi;
        cell_result_t pending_cells[$];
        int           errors;
        int           checked;
        int           sat_seen;

        function new();
            foreach (level[b, i]) level[b][i] = 0;
            bank = 0;
            coef_out = 298262;
            coef_in = 103204;
            cx = 50; cy = 50; rx = 10; ry = 40; hlo = 50; hhi = 80;
            errors = 0;
            checked = 0;
            sat_seen = 0;
        endfunction

        function void set_reg(t_cfg_index idx, logic [COEF_W-1:0] d);
            case (idx)
                REG_COEF_OUTSIDE: coef_out = d;
                REG_COEF_INSIDE:  coef_in = d;
                REG_LENS_CX:      cx = d[6:0];
                REG_LENS_CY:      cy = d[6:0];
                REG_LENS_RX:      rx = d[6:0];
                REG_LENS_RY:      ry = d[6:0];
                REG_HOLE_LOW:     hlo = d[6:0];
                default:          hhi = d[6:0];
            endcase
        endfunction

        function longint clamp(longint v, inout bit sat);
            longint hi;
            longint lo;
            hi = (64'sd1 <<< (FIELD_BITS - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                sat = 1;
                return hi;
            end
            if (v < lo) begin
                sat = 1;
                return lo;
            end
            return v;
        endfunction

        function void note_action(t_action act, logic signed [FIELD_BITS-1:0] src,
                                  logic [CELL_W-1:0] x, logic [CELL_W-1:0] y);
            cell_result_t r;
            int           c, n;
            longint       s, cv, lap, prod, nv, ox, oy;
            r.value = '0;
            r.sat = 0;
            c = bank;
            n = !bank;
            if (act == ACT_STEP) begin
                s = clamp(longint'(src), r.sat);
                for (int row = 0; row < GRID_Y; row++) begin
                    if (row > SOURCE_MARGIN && row < GRID_Y - SOURCE_MARGIN)
                        level[c][row*GRID_X] = int'(s);
                    if (WALL_COLUMN < GRID_X && (row < hlo || row > hhi))
                        level[c][row*GRID_X + WALL_COLUMN] = 0;
                end
                for (int row = 0; row < GRID_Y; row++) begin
                    for (int col = 0; col < GRID_X; col++) begin
                        if (col == 0 || row == 0 || col == GRID_X-1 || row == GRID_Y-1) begin
                            level[n][row*GRID_X + col] = 0;
                            continue;
                        end
                        cv = level[c][row*GRID_X + col];
                        lap = longint'(level[c][row*GRID_X + col + 1])
                            + level[c][row*GRID_X + col - 1]
                            + level[c][(row+1)*GRID_X + col]
                            + level[c][(row-1)*GRID_X + col] - 4 * cv;
                        ox = col - cx;
                        oy = row - cy;
                        if (ox*ox*ry*ry + oy*oy*rx*rx < rx*rx*ry*ry)
                            prod = lap * coef_in;
                        else
                            prod = lap * coef_out;
                        // Round to nearest at 2^-32, halves going up.
                        nv = 2 * cv - level[n][row*GRID_X + col]
                           + ((prod + 64'sd2147483648) >>> 32);
                        level[n][row*GRID_X + col] = int'(clamp(nv, r.sat));
                    end
                end
                bank = !bank;
                if (r.sat) sat_seen++;
            end else if (act == ACT_READ) begin
                if (x < GRID_X && y < GRID_Y)
                    r.value = level[c][int'(y)*GRID_X + int'(x)];
            end else if (act == ACT_CLEAR) begin
                foreach (level[b, i]) level[b][i] = 0;
            end
            pending_cells.push_back(r);
        endfunction

        function void check_result(logic signed [FIELD_BITS-1:0] v, logic s);
            cell_result_t e;
            if (pending_cells.size() == 0) begin
                $error("result with nothing expected: cell_value %0d saturated %0d", v, s);
                errors++;
                return;
            end
            e = pending_cells.pop_front();
            checked++;
            if (v !== e.value) begin
                $error("cell_value: expected %0d, actual %0d", e.value, v);
                errors++;
            end
            if (s !== e.sat) begin
                $error("saturated: expected %0d, actual %0d", e.sat, s);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk = 0;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [ACT_W-1:0]             i_action;
    logic signed [FIELD_BITS-1:0] i_source_now;
    logic [CELL_W-1:0]            i_cell_x;
    logic [CELL_W-1:0]            i_cell_y;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic signed [FIELD_BITS-1:0] o_cell_value;
    logic                         o_saturated;
    logic                         i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [COEF_W-1:0]            i_cfg_wdata;

    field_scoreboard sb;
    int     in_idle;
    int     out_idle;
    longint cycles;
    int     steps_sent;
    int     reads_sent;

    wave_grid_fdtd_step_top dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(negedge i_clk) i_out_stall = ($urandom_range(99) < out_idle);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_cell_value, o_saturated);
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("wave_grid_fdtd_step_top_test NOT OK");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_index idx, logic [COEF_W-1:0] d);
        i_cfg_wr_en = 1;
        i_cfg_index = idx;
        i_cfg_wdata = d;
        sb.set_reg(idx, d);
        @(negedge i_clk);
        i_cfg_wr_en = 0;
    endtask

    task automatic send(t_action act, logic signed [FIELD_BITS-1:0] src,
                        logic [CELL_W-1:0] x, logic [CELL_W-1:0] y);
        while ($urandom_range(99) < in_idle) begin
            i_in_valid = 0;
            @(negedge i_clk);
        end
        i_in_valid = 1;
        i_action = act;
        i_source_now = src;
        i_cell_x = x;
        i_cell_y = y;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_action(act, src, x, y);
        if (act == ACT_STEP) steps_sent++;
        if (act == ACT_READ) reads_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 0;
        while (sb.pending_cells.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic read_near_source();
        logic [CELL_W-1:0] x;
        x = ($urandom_range(99) < 70) ? CELL_W'($urandom_range(31)) : CELL_W'($urandom);
        send(ACT_READ, FIELD_BITS'($urandom), x, CELL_W'($urandom));
    endtask

    task automatic random_items(int count);
        int pick;
        for (int k = 0; k < count; k++) begin
            if (k == 10) drain();
            pick = $urandom_range(99);
            if (pick < 25)
                send(ACT_STEP, FIELD_BITS'($urandom), CELL_W'($urandom), CELL_W'($urandom));
            else if (pick < 88)
                read_near_source();
            else if (pick < 94)
                send(ACT_CLEAR, FIELD_BITS'($urandom), CELL_W'($urandom), CELL_W'($urandom));
            else
                send(ACT_NONE, FIELD_BITS'($urandom), CELL_W'($urandom), CELL_W'($urandom));
        end
        drain();
    endtask

    initial begin
        sb = new();
        cycles = 0;
        steps_sent = 0;
        reads_sent = 0;
        in_idle = 0;
        out_idle = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_out_stall = 0;
        i_action = ACT_NONE;
        i_source_now = '0;
        i_cell_x = '0;
        i_cell_y = '0;
        i_cfg_wr_en = 0;
        i_cfg_index = REG_COEF_OUTSIDE;
        i_cfg_wdata = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;

        // Directed part with the reset configuration.
        send(ACT_READ, '0, 7'd0, 7'd10);
        send(ACT_STEP, 24'sh7FFFFF, 7'd0, 7'd0);
        send(ACT_STEP, 24'sh800000, 7'd0, 7'd0);
        send(ACT_READ, '0, 7'd0, 7'd10);
        send(ACT_READ, '0, 7'd1, 7'd10);
        send(ACT_READ, '0, 7'd0, 7'd5);
        send(ACT_READ, '0, 7'd0, 7'd122);
        send(ACT_READ, '0, 7'd127, 7'd127);
        send(ACT_STEP, 24'sh7FFFFF, 7'd127, 7'd127);
        send(ACT_STEP, 24'sh000000, 7'd0, 7'd0);
        send(ACT_READ, '0, 7'd2, 7'd64);
        send(ACT_READ, '0, 7'd15, 7'd3);
        send(ACT_READ, '0, 7'd14, 7'd60);
        send(ACT_NONE, 24'sh7FFFFF, 7'd127, 7'd127);
        send(ACT_READ, '0, 7'd1, 7'd64);
        send(ACT_CLEAR, '0, 7'd0, 7'd0);
        send(ACT_READ, '0, 7'd1, 7'd64);
        drain();

        // Unstable coefficient outside, lens in a corner, wall closed.
        in_idle = 29;
        out_idle = 65;
        write_reg(REG_COEF_OUTSIDE, 31'h7FFFFFFF);
        write_reg(REG_COEF_INSIDE, 31'd0);
        write_reg(REG_LENS_CX, 31'd0);
        write_reg(REG_LENS_CY, 31'd127);
        write_reg(REG_LENS_RX, 31'd127);
        write_reg(REG_LENS_RY, 31'd1);
        write_reg(REG_HOLE_LOW, 31'd90);
        write_reg(REG_HOLE_HIGH, 31'd20);
        random_items(30);

        // Mirror image of the settings above, wall fully open.
        in_idle = 65;
        out_idle = 29;
        write_reg(REG_COEF_OUTSIDE, 31'd0);
        write_reg(REG_COEF_INSIDE, 31'h7FFFFFFF);
        write_reg(REG_LENS_CX, 31'd127);
        write_reg(REG_LENS_CY, 31'd0);
        write_reg(REG_LENS_RX, 31'd1);
        write_reg(REG_LENS_RY, 31'd127);
        write_reg(REG_HOLE_LOW, 31'd0);
        write_reg(REG_HOLE_HIGH, 31'd127);
        random_items(30);

        // Moderate, stable coefficients with a random lens and aperture.
        in_idle = 0;
        out_idle = 0;
        write_reg(REG_COEF_OUTSIDE, COEF_W'($urandom_range(32'h3FFFFFFF)));
        write_reg(REG_COEF_INSIDE, COEF_W'($urandom_range(32'h3FFFFFFF)));
        write_reg(REG_LENS_CX, COEF_W'($urandom_range(10, 40)));
        write_reg(REG_LENS_CY, COEF_W'($urandom_range(127)));
        write_reg(REG_LENS_RX, COEF_W'($urandom_range(1, 127)));
        write_reg(REG_LENS_RY, COEF_W'($urandom_range(1, 127)));
        write_reg(REG_HOLE_LOW, COEF_W'($urandom_range(127)));
        write_reg(REG_HOLE_HIGH, COEF_W'($urandom_range(127)));
        random_items(30);

        repeat (40) @(negedge i_clk);
        $display("Ran %0d steps and %0d cell reads under four register settings;",
                 steps_sent, reads_sent);
        $display("%0d results checked, %0d steps expected to saturate.",
                 sb.checked, sb.sat_seen);
        if (sb.errors == 0 && sb.pending_cells.size() == 0)
            $display("wave_grid_fdtd_step_top_test OK");
        else
            $display("wave_grid_fdtd_step_top_test NOT OK");
        $finish;
    end
endmodule
